[rtl/stp_pkg.sv]
// ----------------------------------------------------------------------------
// String-to-unsigned parser package
// Beat types, character codes and the digit classifier shared by the front
// stage, the queue and the back stage.
// ----------------------------------------------------------------------------
package stp_pkg;

	// Base register reset value and limits.
	localparam logic [5:0]  BASE_RESET = 6'd10;
	localparam logic [5:0]  BASE_LIMIT = 6'd36;
	localparam logic [5:0]  BASE_ONE   = 6'd1;
	localparam logic [5:0]  BASE_AUTO  = 6'd0;
	localparam logic [5:0]  BASE_OCT   = 6'd8;
	localparam logic [5:0]  BASE_DEC   = 6'd10;
	localparam logic [5:0]  BASE_HEX   = 6'd16;

	// Digit value for a character that is no digit at all.
	localparam logic [5:0]  NO_DIGIT   = 6'd63;
	localparam logic [15:0] MAX_OFFSET = 16'hFFFF;

	// Default depth of the queue between the front and back stages.
	localparam int          FIFO_DEPTH = 4;

	// ASCII codes used by the classifier.
	localparam logic [7:0]  CH_PLUS  = 8'h2B;
	localparam logic [7:0]  CH_MINUS = 8'h2D;
	localparam logic [7:0]  CH_0     = 8'h30;
	localparam logic [7:0]  CH_9     = 8'h39;
	localparam logic [7:0]  CH_UA    = 8'h41;
	localparam logic [7:0]  CH_UX    = 8'h58;
	localparam logic [7:0]  CH_UZ    = 8'h5A;
	localparam logic [7:0]  CH_LA    = 8'h61;
	localparam logic [7:0]  CH_LX    = 8'h78;
	localparam logic [7:0]  CH_LZ    = 8'h7A;
	localparam logic [7:0]  LETTER_BIAS = 8'd10;

	// Input beat: one character of a string.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_beat_t;

	// Result beat: one per string.
	typedef struct packed {
		logic [63:0] value;
		logic        valid_res;
		logic [15:0] end_offset;
	} res_beat_t;

	// Classified character as it travels through the queue.
	typedef struct packed {
		logic [5:0] digit;
		logic       is_sign;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       last;
		logic [5:0] base;
	} cls_beat_t;

	// Queue status seen by both stages.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Value of a base-36 digit in either letter case, or NO_DIGIT.
	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [5:0] d;
		d = NO_DIGIT;
		if (c >= CH_0 && c <= CH_9) begin
			d = 6'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = 6'(c - CH_LA + LETTER_BIAS);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = 6'(c - CH_UA + LETTER_BIAS);
		end
		return d;
	endfunction

endpackage

[rtl/stp_front.sv]
// ----------------------------------------------------------------------------
// Front stage
// Accepts characters, classifies them and holds one classified beat for
// the queue, stalling the source only when the queue is full.
// ----------------------------------------------------------------------------
module stp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  stp_pkg::in_beat_t     in_data,
	input  logic [5:0]            base,
	input  stp_pkg::fifo_stat_t   fifo_stat,
	output logic                  push,
	output stp_pkg::cls_beat_t    push_data
);
	import stp_pkg::*;

	logic      valid_s1;
	cls_beat_t beat_s1;
	cls_beat_t cls;

	// Classify the incoming character.
	always_comb begin
		cls.digit    = digit_of(in_data.ch);
		cls.is_sign  = (in_data.ch == CH_PLUS) || (in_data.ch == CH_MINUS);
		cls.is_minus = (in_data.ch == CH_MINUS);
		cls.is_zero  = (in_data.ch == CH_0);
		cls.is_x     = (in_data.ch == CH_LX) || (in_data.ch == CH_UX);
		cls.last     = in_data.last;
		cls.base     = base;
	end

	// The stage holds its beat while the queue is full.
	assign in_stall  = valid_s1 && fifo_stat.full;
	assign push      = valid_s1 && !fifo_stat.full;
	assign push_data = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			beat_s1 <= cls;
		end
	end

endmodule

[rtl/stp_fifo.sv]
// ----------------------------------------------------------------------------
// Beat queue
// Short first-in first-out queue of classified beats between the front and
// back stages; the head is visible without a read cycle.
// ----------------------------------------------------------------------------
module stp_fifo #(
	parameter int DEPTH = stp_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  stp_pkg::cls_beat_t   wdata,
	input  logic                 pop,
	output stp_pkg::cls_beat_t   rdata,
	output stp_pkg::fifo_stat_t  stat
);
	import stp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cls_beat_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/stp_back.sv]
// ----------------------------------------------------------------------------
// Back stage
// Runs the sign, prefix and digit state machine on classified beats, with
// one multiply-add per digit, and holds each string's result in an output
// register.
// ----------------------------------------------------------------------------
module stp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stp_pkg::cls_beat_t   head,
	input  stp_pkg::fifo_stat_t  fifo_stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output stp_pkg::res_beat_t   out_data
);
	import stp_pkg::*;

	typedef enum logic [2:0] {
		PH_START,
		PH_PREFIX,
		PH_ZERO,
		PH_BODY,
		PH_DONE,
		PH_BAD
	} phase_t;

	phase_t      phase_q;
	logic [63:0] acc_q;
	logic [5:0]  eb_q;
	logic        neg_q;
	logic        seen_q;
	logic [15:0] pos_q;
	logic [15:0] stop_q;

	logic        out_valid_q;
	logic [63:0] out_acc_q;
	logic        out_neg_q;
	logic        out_ok_q;
	logic [15:0] out_off_q;

	phase_t      n_phase;
	logic [63:0] n_acc;
	logic [5:0]  n_eb;
	logic        n_neg;
	logic        n_seen;
	logic [15:0] n_stop;
	logic        body;
	logic        prefix;
	logic        bad_base;
	logic [15:0] pos_inc;
	logic [37:0] prod_lo;
	logic [37:0] prod_hi;
	logic [63:0] mac;
	logic        res_ok;

	assign pos_inc  = (pos_q == MAX_OFFSET) ? pos_q : 16'(pos_q + 1'b1);
	assign bad_base = (head.base == BASE_ONE) || (head.base > BASE_LIMIT);

	// The head is taken unless it closes a string and the result register
	// is still held.
	assign pop = !fifo_stat.empty && (!head.last || !out_valid_q || !out_stall);

	// Multiply-add split into two 32-bit halves times the base.
	assign prod_lo = acc_q[31:0]  * {32'd0, n_eb};
	assign prod_hi = acc_q[63:32] * {32'd0, n_eb};
	assign mac     = {prod_hi[31:0], 32'd0} + {26'd0, prod_lo} + {58'd0, head.digit};

	// Next-state logic for one beat.
	always_comb begin
		n_phase = phase_q;
		n_acc   = acc_q;
		n_eb    = eb_q;
		n_neg   = neg_q;
		n_seen  = seen_q;
		n_stop  = stop_q;
		body    = 1'b0;
		prefix  = 1'b0;

		case (phase_q)
			PH_START: begin
				n_eb = head.base;
				if (bad_base) begin
					n_phase = PH_BAD;
				end else if (head.is_sign) begin
					n_neg   = head.is_minus;
					n_phase = PH_PREFIX;
				end else begin
					prefix = 1'b1;
				end
			end
			PH_PREFIX: begin
				prefix = 1'b1;
			end
			PH_ZERO: begin
				n_phase = PH_BODY;
				if (head.is_x) begin
					n_eb = BASE_HEX;
				end else begin
					if (eb_q == BASE_AUTO) begin
						n_eb = BASE_OCT;
					end
					n_seen = 1'b1;
					body   = 1'b1;
				end
			end
			PH_BODY: begin
				body = 1'b1;
			end
			default: begin
			end
		endcase

		// A possible prefix zero in auto or hex base waits for the next beat.
		if (prefix) begin
			if (head.is_zero && (n_eb == BASE_HEX || n_eb == BASE_AUTO)) begin
				n_phase = PH_ZERO;
			end else begin
				if (n_eb == BASE_AUTO) begin
					n_eb = BASE_DEC;
				end
				n_phase = PH_BODY;
				body    = 1'b1;
			end
		end

		// Digit accumulation; the first non-digit ends the number.
		if (body) begin
			if (head.digit < n_eb) begin
				n_acc  = mac;
				n_seen = 1'b1;
			end else begin
				n_stop  = pos_q;
				n_phase = PH_DONE;
			end
		end

		// Closing the string.
		if (head.last) begin
			if (n_phase == PH_ZERO) begin
				n_seen = 1'b1;
				n_stop = pos_inc;
			end else if (n_phase == PH_BODY) begin
				n_stop = pos_inc;
			end
		end
		res_ok = n_seen && (n_phase != PH_BAD);
	end

	// String state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			acc_q       <= '0;
			eb_q        <= '0;
			neg_q       <= 1'b0;
			seen_q      <= 1'b0;
			pos_q       <= '0;
			stop_q      <= '0;
			out_valid_q <= 1'b0;
			out_acc_q   <= '0;
			out_neg_q   <= 1'b0;
			out_ok_q    <= 1'b0;
			out_off_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall && !(pop && head.last)) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.last) begin
					out_valid_q <= 1'b1;
					out_ok_q    <= res_ok;
					out_acc_q   <= res_ok ? n_acc : '0;
					out_neg_q   <= res_ok && n_neg;
					out_off_q   <= res_ok ? n_stop : '0;
					phase_q     <= PH_START;
					acc_q       <= '0;
					eb_q        <= '0;
					neg_q       <= 1'b0;
					seen_q      <= 1'b0;
					pos_q       <= '0;
					stop_q      <= '0;
				end else begin
					phase_q <= n_phase;
					acc_q   <= n_acc;
					eb_q    <= n_eb;
					neg_q   <= n_neg;
					seen_q  <= n_seen;
					pos_q   <= pos_inc;
					stop_q  <= n_stop;
				end
			end
		end
	end

	// Negation is applied after the result register.
	assign out_valid           = out_valid_q;
	assign out_data.value      = out_neg_q ? 64'(64'd0 - out_acc_q) : out_acc_q;
	assign out_data.valid_res  = out_ok_q;
	assign out_data.end_offset = out_off_q;

endmodule

[rtl/string_to_unsigned_parser_top.sv]
// Path: with the queue empty and the output free, the last character is
// registered in the front stage, written to the queue, and its result is
// then captured in the result register.
// Throughput: one character per cycle while in_stall is low; the back stage
// does one 64-bit by 6-bit multiply-add per character, which sets the clock path.
// Reset: arst_n clears all string state and the queue, and sets base to 10.
// ----------------------------------------------------------------------------
// String-to-unsigned parser, top level
// Streams characters through a classifying front stage and a short queue
// into the parsing back stage; one result beat per string.
// ----------------------------------------------------------------------------
module string_to_unsigned_parser_top #(
	parameter int FIFO_DEPTH = stp_pkg::FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stp_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output stp_pkg::res_beat_t out_data,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata
);
	import stp_pkg::*;

	logic       [5:0] base_q;
	fifo_stat_t       fifo_stat;
	logic             push;
	cls_beat_t        push_data;
	cls_beat_t        head;
	logic             pop;

	// Base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	stp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.base      (base_q),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_data (push_data)
	);

	stp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (head),
		.stat   (fifo_stat)
	);

	stp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// A result that is not valid carries zero value and zero offset.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.valid_res) |->
		(out_data.value == 64'd0 && out_data.end_offset == 16'd0))
		else $error("invalid result with non-zero payload");

	// A valid result has consumed at least one character.
	a_valid_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.valid_res) |-> (out_data.end_offset != 16'd0))
		else $error("valid result with zero offset");

	// A new result only follows a beat taken from the queue.
	a_result_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop && head.last))
		else $error("result appeared without a closing beat");

	// The queue never overflows nor underflows.
	a_fifo_guard: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fifo_stat.full) && !(pop && fifo_stat.empty))
		else $error("queue overflow or underflow");
`endif

endmodule
